// ----- design/fba_pkg.sv -----
// Shared constants, codes and control structs of the fixed block allocator.
`timescale 1ns / 1ps

package fba_pkg;

   // Default heap geometry
   localparam int HEAP_WORDS_DEF = 32;
   localparam int MAX_BLOCKS_DEF = 16;

   // Block size register: reset value and legal range
   localparam int BW_RESET = 8;
   localparam int BW_MIN   = 2;
   localparam int BW_MAX   = 32;

   // First payload word of block 0
   localparam int HEAP_BASE = 2;

   // Field widths
   localparam int OP_W    = 1;
   localparam int SIZE_W  = 6;
   localparam int ADDR_W  = 5;
   localparam int STAT_W  = 2;
   localparam int SPAN_W  = 5;
   localparam int BW_W    = 6;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_HEAP_FULL = 2'd2,
      ST_BAD_FREE  = 2'd3
   } status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       start;         // latch request, rewind the block walk
      logic       step;          // advance to the next block
      logic       commit_alloc;  // mark block used, grow top if needed
      logic       commit_free;   // mark block free
      logic       shrink_step;   // drop top by one block
      logic       rd_top;        // flag read at top-1 instead of walk index
      logic       set_status;
      status_type status;
      logic       load_rsp;      // move result into the output register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic oversize;     // request does not fit in a block payload
      logic alloc_stop;   // walk reached a free block, the top or the limit
      logic fit_ok;       // block at walk index fits in the heap
      logic free_stop;    // walk reached or passed the address, or the top
      logic free_ok;      // address names a block in use
      logic last_block;   // walk index is the highest block
      logic shrink_stop;  // top is zero or the block under it is in use
      logic rsp_busy;     // output register holds a result not yet taken
   } flags_type;

endpackage

// ----- design/fba_channels.sv -----
// Valid/ready channel interfaces for request, response and block size register.
`timescale 1ns / 1ps

interface fba_req_if;
   logic                         valid;
   logic                         ready;
   logic [fba_pkg::OP_W-1:0]     operation;
   logic [fba_pkg::SIZE_W-1:0]   request_size;
   logic [fba_pkg::ADDR_W-1:0]   free_address;

   modport source (output valid, operation, request_size, free_address, input ready);
   modport sink   (input valid, operation, request_size, free_address, output ready);
endinterface

interface fba_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fba_pkg::ADDR_W-1:0]   block_address;
   logic [fba_pkg::STAT_W-1:0]   status;
   logic [fba_pkg::SPAN_W-1:0]   blocks_spanned;

   modport source (output valid, block_address, status, blocks_spanned, input ready);
   modport sink   (input valid, block_address, status, blocks_spanned, output ready);
endinterface

interface fba_csr_if;
   logic                         valid;
   logic                         ready;
   logic [fba_pkg::BW_W-1:0]     block_words;

   modport source (output valid, block_words, input ready);
   modport sink   (input valid, block_words, output ready);
endinterface

// ----- design/fba_datapath.sv -----
// Allocator datapath: block flags, top count, block walk, size register, result register.
`timescale 1ns / 1ps

module fba_datapath #(
   parameter int HEAP_WORDS = fba_pkg::HEAP_WORDS_DEF,
   parameter int MAX_BLOCKS = fba_pkg::MAX_BLOCKS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fba_pkg::cmd_type           cmd,
   output fba_pkg::flags_type         flags,
   input  logic [fba_pkg::SIZE_W-1:0] req_size,
   input  logic [fba_pkg::ADDR_W-1:0] req_addr,
   input  logic                       csr_write,
   input  logic [fba_pkg::BW_W-1:0]   csr_data,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [fba_pkg::ADDR_W-1:0] rsp_addr,
   output logic [fba_pkg::STAT_W-1:0] rsp_status,
   output logic [fba_pkg::SPAN_W-1:0] rsp_span
);

   localparam int K_W    = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int BASE_W = $clog2(HEAP_WORDS + 2 * fba_pkg::BW_MAX) + 1;
   localparam int SUM_W  = BASE_W + 1;

   // Control state
   logic                      used_ff [MAX_BLOCKS];
   logic                      used_in [MAX_BLOCKS];
   logic [K_W-1:0]            top_ff, top_in;
   logic [fba_pkg::BW_W-1:0]  bw_ff, bw_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [fba_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [fba_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [K_W-1:0]             k_ff, k_in;
   logic [BASE_W-1:0]          base_ff, base_in;
   logic [BASE_W-1:0]          res_addr_ff, res_addr_in;
   fba_pkg::status_type        stat_ff, stat_in;
   logic [fba_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [fba_pkg::STAT_W-1:0] rsp_stat_ff, rsp_stat_in;
   logic [fba_pkg::SPAN_W-1:0] rsp_span_ff, rsp_span_in;

   logic [K_W-1:0]   rd_cnt;
   logic             used_rd;
   logic [SUM_W-1:0] block_end;

   // Single flag read port: walk index, or the block just under the top
   always_comb begin
      rd_cnt  = cmd.rd_top ? (top_ff - K_W'(1)) : k_ff;
      used_rd = (rd_cnt < K_W'(MAX_BLOCKS)) && used_ff[rd_cnt[IDX_W-1:0]];
   end

   // One past the last word of the block at the walk index
   assign block_end = SUM_W'(base_ff) + SUM_W'(bw_ff);

   // Status toward the controller
   always_comb begin
      flags.oversize    = size_ff >= bw_ff;
      flags.alloc_stop  = (k_ff == top_ff) || (k_ff == K_W'(MAX_BLOCKS)) || !used_rd;
      flags.fit_ok      = (k_ff < K_W'(MAX_BLOCKS)) &&
                          (block_end <= SUM_W'(HEAP_WORDS + 1));
      flags.free_stop   = (k_ff >= top_ff) || (base_ff >= BASE_W'(addr_ff));
      flags.free_ok     = (base_ff == BASE_W'(addr_ff)) && (k_ff < top_ff) && used_rd;
      flags.last_block  = (k_ff + K_W'(1)) == top_ff;
      flags.shrink_stop = (top_ff == '0) || used_rd;
      flags.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   // Next-state logic
   always_comb begin
      used_in      = used_ff;
      top_in       = top_ff;
      bw_in        = bw_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      res_addr_in  = res_addr_ff;
      stat_in      = stat_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_span_in  = rsp_span_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // Block size register, saturated, only while the heap is empty
      if (csr_write && top_ff == '0) begin
         if (csr_data < fba_pkg::BW_W'(fba_pkg::BW_MIN)) begin
            bw_in = fba_pkg::BW_W'(fba_pkg::BW_MIN);
         end else if (csr_data > fba_pkg::BW_W'(fba_pkg::BW_MAX)) begin
            bw_in = fba_pkg::BW_W'(fba_pkg::BW_MAX);
         end else begin
            bw_in = csr_data;
         end
      end

      if (cmd.start) begin
         size_in     = req_size;
         addr_in     = req_addr;
         k_in        = '0;
         base_in     = BASE_W'(fba_pkg::HEAP_BASE);
         res_addr_in = '0;
         stat_in     = fba_pkg::ST_OK;
      end

      if (cmd.step) begin
         k_in    = k_ff + K_W'(1);
         base_in = base_ff + BASE_W'(bw_ff);
      end

      if (cmd.commit_alloc) begin
         used_in[k_ff[IDX_W-1:0]] = 1'b1;
         res_addr_in = base_ff;
         if (k_ff == top_ff) begin
            top_in = top_ff + K_W'(1);
         end
      end

      if (cmd.commit_free) begin
         used_in[k_ff[IDX_W-1:0]] = 1'b0;
      end

      if (cmd.shrink_step) begin
         top_in = top_ff - K_W'(1);
      end

      if (cmd.set_status) begin
         stat_in = cmd.status;
      end

      // Result transfer into the output register
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = res_addr_ff[fba_pkg::ADDR_W-1:0];
         rsp_stat_in  = stat_ff;
         rsp_span_in  = fba_pkg::SPAN_W'(top_ff);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '{default: 1'b0};
         top_ff       <= '0;
         bw_ff        <= fba_pkg::BW_W'(fba_pkg::BW_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         top_ff       <= top_in;
         bw_ff        <= bw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      addr_ff     <= addr_in;
      k_ff        <= k_in;
      base_ff     <= base_in;
      res_addr_ff <= res_addr_in;
      stat_ff     <= stat_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_span_ff <= rsp_span_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign rsp_status = rsp_stat_ff;
   assign rsp_span   = rsp_span_ff;

endmodule

// ----- design/fba_controller.sv -----
// Allocator control state machine: block walk, commit, top shrink, result hand-off.
`timescale 1ns / 1ps

module fba_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [fba_pkg::OP_W-1:0] req_op,
   output logic                     req_ready,
   input  fba_pkg::flags_type       flags,
   output fba_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_SCAN,
      S_FREE_SCAN,
      S_SHRINK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.status = fba_pkg::ST_OK;
      req_ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = (req_op == fba_pkg::OP_FREE) ? S_FREE_SCAN : S_ALLOC_SCAN;
            end
         end

         S_ALLOC_SCAN: begin
            if (flags.oversize) begin
               cmd.set_status = 1'b1;
               cmd.status     = fba_pkg::ST_TOO_LARGE;
               state_in       = S_DONE;
            end else if (flags.alloc_stop) begin
               if (flags.fit_ok) begin
                  cmd.commit_alloc = 1'b1;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status     = fba_pkg::ST_HEAP_FULL;
               end
               state_in = S_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end

         S_FREE_SCAN: begin
            if (flags.free_stop) begin
               if (flags.free_ok) begin
                  cmd.commit_free = 1'b1;
                  state_in        = flags.last_block ? S_SHRINK : S_DONE;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status     = fba_pkg::ST_BAD_FREE;
                  state_in       = S_DONE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end

         // Lower the top past trailing free blocks, one per cycle
         S_SHRINK: begin
            cmd.rd_top = 1'b1;
            if (flags.shrink_stop) begin
               state_in = S_DONE;
            end else begin
               cmd.shrink_step = 1'b1;
            end
         end

         S_DONE: begin
            if (!flags.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/fixed_block_allocator.sv -----
// Fixed block allocator top level: controller, datapath and channel hookup.
// An allocate walks the block flags from block 0 up to the block it lands on before the
// result loads; a free walks up to block k and then releases any trailing free blocks.
// One item at a time, the next request taken in the cycle after the result loads; the
// flag walk and top shrink move one block per cycle.
// Synchronous reset clears all block flags, sets the top to zero and block_words to 8.
`timescale 1ns / 1ps

module fixed_block_allocator #(
   parameter int HEAP_WORDS = fba_pkg::HEAP_WORDS_DEF,
   parameter int MAX_BLOCKS = fba_pkg::MAX_BLOCKS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   fba_req_if.sink    req_chan,
   fba_rsp_if.source  rsp_chan,
   fba_csr_if.sink    csr_chan
);

   fba_pkg::cmd_type   cmd;
   fba_pkg::flags_type flags;

   // Register writes are always taken
   assign csr_chan.ready = 1'b1;

   fba_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.operation),
      .req_ready (req_chan.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   fba_datapath #(
      .HEAP_WORDS (HEAP_WORDS),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .flags      (flags),
      .req_size   (req_chan.request_size),
      .req_addr   (req_chan.free_address),
      .csr_write  (csr_chan.valid),
      .csr_data   (csr_chan.block_words),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_addr   (rsp_chan.block_address),
      .rsp_status (rsp_chan.status),
      .rsp_span   (rsp_chan.blocks_spanned)
   );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the fixed block allocator: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module tb;

   localparam int HEAP    = fba_pkg::HEAP_WORDS_DEF;
   localparam int MAX_BLK = fba_pkg::MAX_BLOCKS_DEF;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned MAX_REPORTS = 200;

   typedef struct packed {
      logic [fba_pkg::ADDR_W-1:0] block_address;
      fba_pkg::status_type        status;
      logic [fba_pkg::SPAN_W-1:0] spanned;
   } outcome_type;

   // Shadow of the heap bookkeeping plus the queue of outcomes still owed by the block
   class heap_tracker;
      bit          in_use[MAX_BLK];
      int unsigned top;
      int unsigned words;
      outcome_type owed[$];
      int unsigned faults;

      function new();
         foreach (in_use[k])
            in_use[k] = 1'b0;
         top    = 0;
         words  = fba_pkg::BW_RESET;
         faults = 0;
      endfunction

      // Block size write; saturated, and dropped while any block is in use
      function void set_block_words(logic [fba_pkg::BW_W-1:0] value);
         int unsigned w;
         w = value;
         if (top != 0)
            return;
         if (w < fba_pkg::BW_MIN)
            w = fba_pkg::BW_MIN;
         if (w > fba_pkg::BW_MAX)
            w = fba_pkg::BW_MAX;
         words = w;
      endfunction

      // Number of blocks that fit in the heap at the current block size
      function int unsigned capacity();
         int unsigned k;
         k = 0;
         while (k < MAX_BLK && fba_pkg::HEAP_BASE + k * words + words - 1 <= HEAP)
            k++;
         return k;
      endfunction

      // Apply one accepted request to the shadow state and queue its outcome
      function void note_request(logic [fba_pkg::OP_W-1:0] op,
                                 logic [fba_pkg::SIZE_W-1:0] size,
                                 logic [fba_pkg::ADDR_W-1:0] addr);
         outcome_type o;
         int unsigned k;
         int unsigned a;
         o.block_address = '0;
         o.status        = fba_pkg::ST_OK;
         if (op == fba_pkg::OP_ALLOC) begin
            if (size >= words) begin
               o.status = fba_pkg::ST_TOO_LARGE;
            end else begin
               // first fit below the top, else grow the top
               k = 0;
               while (k < top && k < MAX_BLK && in_use[k])
                  k++;
               if (k >= MAX_BLK ||
                   fba_pkg::HEAP_BASE + k * words + words - 1 > HEAP) begin
                  o.status = fba_pkg::ST_HEAP_FULL;
               end else begin
                  if (k == top)
                     top++;
                  in_use[k]       = 1'b1;
                  o.block_address = fba_pkg::ADDR_W'(fba_pkg::HEAP_BASE + k * words);
               end
            end
         end else begin
            a = addr;
            if (a < fba_pkg::HEAP_BASE || (a - fba_pkg::HEAP_BASE) % words != 0) begin
               o.status = fba_pkg::ST_BAD_FREE;
            end else begin
               k = (a - fba_pkg::HEAP_BASE) / words;
               if (k >= top || k >= MAX_BLK || !in_use[k]) begin
                  o.status = fba_pkg::ST_BAD_FREE;
               end else begin
                  in_use[k] = 1'b0;
                  // releasing the top block drops the top past trailing free blocks
                  if (k + 1 == top)
                     while (top > 0 && !in_use[top-1])
                        top--;
               end
            end
         end
         o.spanned = fba_pkg::SPAN_W'(top);
         owed.push_back(o);
      endfunction

      // Compare one response transfer with the oldest owed outcome
      function void check_outcome(logic [fba_pkg::ADDR_W-1:0] a,
                                  logic [fba_pkg::STAT_W-1:0] s,
                                  logic [fba_pkg::SPAN_W-1:0] n);
         outcome_type e;
         if (owed.size() == 0) begin
            faults++;
            if (faults <= MAX_REPORTS)
               $error("response transfer with no request outstanding");
            return;
         end
         e = owed.pop_front();
         if (a !== e.block_address) begin
            faults++;
            if (faults <= MAX_REPORTS)
               $error("block_address: expected %0d, actual %0d", e.block_address, a);
         end
         if (s !== e.status) begin
            faults++;
            if (faults <= MAX_REPORTS)
               $error("status: expected %0d, actual %0d", e.status, s);
         end
         if (n !== e.spanned) begin
            faults++;
            if (faults <= MAX_REPORTS)
               $error("blocks_spanned: expected %0d, actual %0d", e.spanned, n);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   fba_req_if req ();
   fba_rsp_if rsp ();
   fba_csr_if csr ();

   fixed_block_allocator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   heap_tracker tracker = new();

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_request  = 1'b0;
   int unsigned cycles        = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   initial begin : watchdog
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Response ready: random stalls, or one long hold-off when asked
   initial begin : rsp_driver
      int unsigned hold_left;
      hold_left = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp.ready = 1'b0;
            hold_left--;
         end else begin
            rsp.ready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready)
         tracker.check_outcome(rsp.block_address, rsp.status, rsp.blocks_spanned);
   end

   // One request transfer, with random idle cycles ahead of it
   task automatic send_item(logic [fba_pkg::OP_W-1:0] op,
                            logic [fba_pkg::SIZE_W-1:0] size,
                            logic [fba_pkg::ADDR_W-1:0] addr);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid        = 1'b1;
      req.operation    = op;
      req.request_size = size;
      req.free_address = addr;
      do @(posedge clock); while (!req.ready);
      tracker.note_request(op, size, addr);
   endtask

   // Stop offering and wait until every owed outcome has come back
   task automatic quiesce();
      @(negedge clock);
      req.valid = 1'b0;
      while (tracker.owed.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_block_words(logic [fba_pkg::BW_W-1:0] value);
      quiesce();
      csr.valid       = 1'b1;
      csr.block_words = value;
      do @(posedge clock); while (!csr.ready);
      tracker.set_block_words(value);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   // Free every block in use, in random order
   task automatic release_all();
      int unsigned live[$];
      forever begin
         live.delete();
         for (int k = 0; k < MAX_BLK; k++)
            if (tracker.in_use[k])
               live.push_back(k);
         if (live.size() == 0)
            break;
         send_item(fba_pkg::OP_FREE, fba_pkg::SIZE_W'($urandom_range(0, 63)),
                   fba_pkg::ADDR_W'(fba_pkg::HEAP_BASE +
                                    live[$urandom_range(0, live.size() - 1)] *
                                    tracker.words));
      end
   endtask

   // Mostly well-formed alloc/free traffic, some oversize, bad frees and noise
   task automatic random_item();
      int unsigned                live[$];
      int unsigned                r;
      logic [fba_pkg::OP_W-1:0]   op;
      logic [fba_pkg::SIZE_W-1:0] sz;
      logic [fba_pkg::ADDR_W-1:0] ad;
      bit                         want_alloc;
      for (int k = 0; k < MAX_BLK; k++)
         if (tracker.in_use[k])
            live.push_back(k);
      r  = $urandom_range(0, 99);
      op = fba_pkg::OP_ALLOC;
      sz = fba_pkg::SIZE_W'($urandom_range(0, 63));
      ad = fba_pkg::ADDR_W'($urandom_range(0, 31));
      if (r < 8) begin
         op = $urandom_range(0, 1) ? fba_pkg::OP_FREE : fba_pkg::OP_ALLOC;
      end else if (r < 13) begin
         op = fba_pkg::OP_ALLOC;
         sz = fba_pkg::SIZE_W'($urandom_range(tracker.words, 63));
      end else if (r < 17) begin
         // free on or next to a block boundary, often not a block in use
         op = fba_pkg::OP_FREE;
         ad = fba_pkg::ADDR_W'(fba_pkg::HEAP_BASE +
                               $urandom_range(0, MAX_BLK - 1) * tracker.words +
                               $urandom_range(0, 1));
      end else begin
         if (live.size() == 0)
            want_alloc = 1'b1;
         else if (live.size() >= tracker.capacity())
            want_alloc = ($urandom_range(0, 99) < 30);
         else
            want_alloc = ($urandom_range(0, 99) < 55);
         if (want_alloc) begin
            op = fba_pkg::OP_ALLOC;
            sz = fba_pkg::SIZE_W'($urandom_range(0, tracker.words - 1));
         end else begin
            op = fba_pkg::OP_FREE;
            ad = fba_pkg::ADDR_W'(fba_pkg::HEAP_BASE +
                                  live[$urandom_range(0, live.size() - 1)] *
                                  tracker.words);
         end
      end
      send_item(op, sz, ad);
   endtask

   logic [fba_pkg::BW_W-1:0] bw_plan[10] = '{6'd2, 6'd5, 6'd32, 6'd0, 6'd16, 6'd63, 6'd3,
                                             6'd11, 6'd1, 6'd7};

   initial begin : stimulus
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.operation    = fba_pkg::OP_ALLOC;
      req.request_size = '0;
      req.free_address = '0;
      csr.valid        = 1'b0;
      csr.block_words  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset block size of 8
      send_item(fba_pkg::OP_ALLOC, 6'd0, 5'd0);
      send_item(fba_pkg::OP_ALLOC, 6'd7, 5'd31);
      send_item(fba_pkg::OP_ALLOC, 6'd8, 5'd0);   // size equal to block size
      send_item(fba_pkg::OP_ALLOC, 6'd63, 5'd0);
      send_item(fba_pkg::OP_ALLOC, 6'd3, 5'd0);
      send_item(fba_pkg::OP_ALLOC, 6'd1, 5'd0);   // heap full
      send_item(fba_pkg::OP_FREE, 6'd0, 5'd0);    // below heap base
      send_item(fba_pkg::OP_FREE, 6'd63, 5'd1);
      send_item(fba_pkg::OP_FREE, 6'd0, 5'd3);    // off a payload boundary
      send_item(fba_pkg::OP_FREE, 6'd0, 5'd26);   // at the top
      send_item(fba_pkg::OP_FREE, 6'd0, 5'd10);
      send_item(fba_pkg::OP_FREE, 6'd0, 5'd10);   // already free
      write_block_words(6'd2);                    // ignored, blocks in use
      send_item(fba_pkg::OP_ALLOC, 6'd5, 5'd0);   // first fit reuses the hole
      send_item(fba_pkg::OP_FREE, 6'd0, 5'd18);
      send_item(fba_pkg::OP_FREE, 6'd0, 5'd2);
      send_item(fba_pkg::OP_FREE, 6'd0, 5'd10);   // top drops past trailing free blocks
      send_item(fba_pkg::OP_FREE, 6'd0, 5'd31);
      write_block_words(6'd2);
      send_item(fba_pkg::OP_ALLOC, 6'd1, 5'd0);
      send_item(fba_pkg::OP_ALLOC, 6'd2, 5'd0);
      send_item(fba_pkg::OP_FREE, 6'd0, 5'd2);
      write_block_words(6'd32);
      send_item(fba_pkg::OP_ALLOC, 6'd31, 5'd0);  // no block fits
      send_item(fba_pkg::OP_ALLOC, 6'd32, 5'd0);
      send_item(fba_pkg::OP_FREE, 6'd0, 5'd2);

      // Random part: one block size per chunk, idling pattern per chunk group
      for (int c = 0; c < 10; c++) begin
         if (c < 4) begin
            send_idle_pct = 29;
            recv_idle_pct = 77;
         end else if (c < 7) begin
            send_idle_pct = 77;
            recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // leave blocks in use before one write so that it is dropped
         if (c != 6)
            release_all();
         write_block_words(bw_plan[c]);
         for (int i = 0; i < 140; i++) begin
            if (c == 7 && i == 30)
               hold_request = 1'b1;
            if (c == 8 && i == 70)
               quiesce();
            random_item();
         end
      end
      release_all();

      // Drain and let any stray response show up
      @(negedge clock);
      req.valid = 1'b0;
      while (tracker.owed.size() != 0)
         @(negedge clock);
      repeat (60) @(negedge clock);
      if (tracker.faults == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
